@@ hdl/uer_pkg.sv @@
// shared types, constants and helper function of the echo ranger
`timescale 1ns / 1ps
package uer_pkg;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PING_PERIOD  = 3'd0,
    CFG_REPORT_EVERY = 3'd1,
    CFG_UM_PER_TICK  = 3'd2,
    CFG_OBST_THRESH  = 3'd3,
    CFG_BLINK_MULT   = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [15:0] PING_PERIOD_RST  = 16'd4000;
  localparam logic [7:0]  REPORT_EVERY_RST = 8'd5;
  localparam logic [15:0] UM_PER_TICK_RST  = 16'd8575;
  localparam logic [31:0] OBST_THRESH_RST  = 32'd100000;
  localparam logic [7:0]  BLINK_MULT_RST   = 8'd80;

  // measurement reset values
  localparam logic [15:0] TICKS_RST    = 16'd1;
  localparam logic [31:0] DISTANCE_RST = 32'd9990000;

  // centimetre conversion: saturation point and reciprocal of 10000
  localparam logic [31:0] DIST_SAT     = 32'd9990000;
  localparam logic [9:0]  CM_MAX       = 10'd999;
  localparam logic [24:0] DIV10K_MUL   = 25'd27487791;
  localparam int unsigned DIV10K_SHIFT = 38;

  // digit split: reciprocals of 100 and 10
  localparam logic [10:0] DIV100_MUL   = 11'd1311;
  localparam int unsigned DIV100_SHIFT = 17;
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int unsigned DIV10_SHIFT  = 11;
  localparam logic [6:0]  HUNDRED      = 7'd100;
  localparam logic [3:0]  TEN          = 4'd10;
  localparam logic [5:0]  ASCII_ZERO   = 6'd48;

  typedef struct packed {
    logic [15:0] ping_period;
    logic [7:0]  report_every;
    logic [15:0] um_per_tick;
    logic [31:0] obst_thresh;
    logic [7:0]  blink_mult;
  } cfg_t;

  // what the tick stage hands to the datapath
  typedef struct packed {
    logic        trigger;
    logic        done;
    logic        report;
    logic [15:0] ticks;
  } tick_res_t;

  typedef struct packed {
    logic [5:0] hundreds;
    logic [5:0] tens;
    logic [5:0] units;
  } digits_t;

  // split 0..999 into three ascii digits
  function automatic digits_t cm_to_chars(input logic [9:0] cm);
    logic [20:0] hprod;
    logic [3:0]  h;
    logic [9:0]  rem10;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [3:0]  t;
    logic [6:0]  urem;
    digits_t     r;
    hprod = 21'(cm) * 21'(DIV100_MUL);
    h     = hprod[DIV100_SHIFT +: 4];
    rem10 = cm - 10'(10'(h) * 10'(HUNDRED));
    rem   = rem10[6:0];
    tprod = 15'(rem) * 15'(DIV10_MUL);
    t     = tprod[DIV10_SHIFT +: 4];
    urem  = rem - 7'(7'(t) * 7'(TEN));
    r.hundreds = ASCII_ZERO + 6'(h);
    r.tens     = ASCII_ZERO + 6'(t);
    r.units    = ASCII_ZERO + 6'(urem[3:0]);
    return r;
  endfunction

endpackage

@@ hdl/uer_if.sv @@
// request channels of the echo ranger: tick input, result output, register writes
`timescale 1ns / 1ps
interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger;
  logic        measurement_done;
  logic [15:0] echo_ticks;
  logic [31:0] distance_um;
  logic        obstacle;
  logic [5:0]  hundreds_char;
  logic [5:0]  tens_char;
  logic [5:0]  units_char;
  logic [15:0] blink_period;
  logic        report_pulse;
  modport source (output valid, output trigger, output measurement_done, output echo_ticks,
                  output distance_um, output obstacle, output hundreds_char,
                  output tens_char, output units_char, output blink_period,
                  output report_pulse, input ready);
  modport sink (input valid, input trigger, input measurement_done, input echo_ticks,
                input distance_um, input obstacle, input hundreds_char,
                input tens_char, input units_char, input blink_period,
                input report_pulse, output ready);
endinterface

interface uer_cfg_if;
  import uer_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/uer_regs.sv @@
// configuration register file of the echo ranger
`timescale 1ns / 1ps
module uer_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  uer_cfg_if.sink         cfg_i,
  output uer_pkg::cfg_t   cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PING_PERIOD:  cfg_d.ping_period  = cfg_i.data[15:0];
        CFG_REPORT_EVERY: cfg_d.report_every = cfg_i.data[7:0];
        CFG_UM_PER_TICK:  cfg_d.um_per_tick  = cfg_i.data[15:0];
        CFG_OBST_THRESH:  cfg_d.obst_thresh  = cfg_i.data[31:0];
        CFG_BLINK_MULT:   cfg_d.blink_mult   = cfg_i.data[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_period  <= PING_PERIOD_RST;
      cfg_q.report_every <= REPORT_EVERY_RST;
      cfg_q.um_per_tick  <= UM_PER_TICK_RST;
      cfg_q.obst_thresh  <= OBST_THRESH_RST;
      cfg_q.blink_mult   <= BLINK_MULT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/uer_tick.sv @@
// tick stage: trigger and report counters, echo edge timing
`timescale 1ns / 1ps
module uer_tick (
  input  logic               clk_i,
  input  logic               rst_ni,
  uer_in_if.sink             in_i,
  input  uer_pkg::cfg_t      cfg_i,
  input  logic               ready_i,
  output logic               valid_o,
  output uer_pkg::tick_res_t res_o
);
  import uer_pkg::*;

  logic [15:0] tick_q, tick_d;
  logic [7:0]  period_q, period_d;
  logic        prev_echo_q;
  logic [15:0] start_q, start_d;
  logic [15:0] ticks_q, ticks_d;
  logic        valid_q;
  tick_res_t   res_q, res_d;
  logic        load;
  logic        accept;
  logic [15:0] tick_inc;
  logic [7:0]  period_inc;
  logic        fire;
  logic        rep;
  logic        rise;
  logic        fall;

  assign load      = !valid_q || ready_i;
  assign in_i.ready = load;
  assign accept    = in_i.valid && load;

  always_comb begin
    tick_inc   = tick_q + 16'd1;
    fire       = (tick_inc >= cfg_i.ping_period);
    tick_d     = fire ? 16'd0 : tick_inc;
    period_inc = fire ? period_q + 8'd1 : period_q;
    rep        = (period_inc >= cfg_i.report_every);
    period_d   = rep ? 8'd0 : period_inc;
    rise       = in_i.echo_level && !prev_echo_q;
    fall       = !in_i.echo_level && prev_echo_q;
    start_d    = rise ? tick_d : start_q;
    ticks_d    = fall ? tick_d - start_q : ticks_q;
  end

  always_comb begin
    res_d.trigger = fire;
    res_d.done    = fall;
    res_d.report  = rep;
    res_d.ticks   = ticks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= 16'd0;
      period_q    <= 8'd0;
      prev_echo_q <= 1'b0;
      start_q     <= 16'd0;
      ticks_q     <= TICKS_RST;
      valid_q     <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= in_i.valid;
      end
      if (accept) begin
        tick_q      <= tick_d;
        period_q    <= period_d;
        prev_echo_q <= in_i.echo_level;
        start_q     <= start_d;
        ticks_q     <= ticks_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hdl/uer_calc.sv @@
// result datapath: distance, obstacle, blink period and centimetre digits
`timescale 1ns / 1ps
module uer_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uer_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  uer_pkg::tick_res_t res_i,
  output logic               ready_o,
  uer_out_if.source          out_o
);
  import uer_pkg::*;

  // stage 1: distance product and blink period
  logic        v1_q;
  tick_res_t   c1_q;
  logic [31:0] dist1_q, dist1_d;
  logic [15:0] blink1_q, blink1_d;
  logic [23:0] blink_prod;

  // stage 2: obstacle compare and centimetre quotient
  logic        v2_q;
  tick_res_t   c2_q;
  logic [31:0] dist2_q;
  logic [15:0] blink2_q;
  logic        obst2_q, obst2_d;
  logic [9:0]  cm2_q, cm2_d;
  logic [48:0] cm_prod;

  // stage 3: result register
  logic        v3_q;
  tick_res_t   c3_q;
  logic [31:0] dist3_q;
  logic [15:0] blink3_q;
  logic        obst3_q;
  digits_t     dig3_q;

  logic en1, en2, en3;

  assign en3     = !v3_q || out_o.ready;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    dist1_d    = res_i.done ? 32'(res_i.ticks) * 32'(cfg_i.um_per_tick) : dist1_q;
    blink_prod = 24'(res_i.ticks) * 24'(cfg_i.blink_mult);
    blink1_d   = (|blink_prod[23:16]) ? 16'hffff : blink_prod[15:0];
  end

  always_comb begin
    obst2_d = c1_q.done ? (dist1_q <= cfg_i.obst_thresh) : obst2_q;
    cm_prod = 49'(dist1_q[23:0]) * 49'(DIV10K_MUL);
    cm2_d   = (dist1_q >= DIST_SAT) ? CM_MAX : cm_prod[DIV10K_SHIFT +: 10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      dist1_q <= DISTANCE_RST;
      obst2_q <= 1'b1;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
        if (valid_i) begin
          dist1_q <= dist1_d;
        end
      end
      if (en2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          obst2_q <= obst2_d;
        end
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      c1_q     <= res_i;
      blink1_q <= blink1_d;
    end
    if (en2 && v1_q) begin
      c2_q     <= c1_q;
      dist2_q  <= dist1_q;
      blink2_q <= blink1_q;
      cm2_q    <= cm2_d;
    end
    if (en3 && v2_q) begin
      c3_q     <= c2_q;
      dist3_q  <= dist2_q;
      blink3_q <= blink2_q;
      obst3_q  <= obst2_q;
      dig3_q   <= cm_to_chars(cm2_q);
    end
  end

  assign out_o.valid            = v3_q;
  assign out_o.trigger          = c3_q.trigger;
  assign out_o.measurement_done = c3_q.done;
  assign out_o.echo_ticks       = c3_q.ticks;
  assign out_o.distance_um      = dist3_q;
  assign out_o.obstacle         = obst3_q;
  assign out_o.hundreds_char    = dig3_q.hundreds;
  assign out_o.tens_char        = dig3_q.tens;
  assign out_o.units_char       = dig3_q.units;
  assign out_o.blink_period     = blink3_q;
  assign out_o.report_pulse     = c3_q.report;

endmodule

@@ hdl/ultrasonic_echo_ranger.sv @@
// top level of the ultrasonic trigger and echo range finder
`timescale 1ns / 1ps
// usage
//  - in_i carries one time-base tick per request, with the sampled echo line level
//  - out_o returns exactly one result per tick: trigger, measurement done, echo length,
//    distance in micrometres, obstacle flag, three ascii centimetre digits, blink period
//    and report pulse
//  - cfg_i writes the five settings by index; it is always ready and should only be
//    used while no tick is in flight
// timing
//  - a tick accepted on in_i passes the tick register and the three calc stage registers
//    before its result shows on out_o, where the receiver can take it
//  - one tick per cycle sustained while out_o is ready; the counters and edge detector
//    close in the tick stage, the products and the divide by 10000 span three register stages
// reset
//  - counters and echo start clear, echo length reads one, distance 9990000 um with
//    obstacle set (digits "999"), settings take their defaults
// backpressure
//  - every stage holds a skid-free register with its own valid; a stalled receiver
//    only blocks in_i once all four stages are full
module ultrasonic_echo_ranger (
  input  logic       clk_i,
  input  logic       rst_ni,
  uer_in_if.sink     in_i,
  uer_out_if.source  out_o,
  uer_cfg_if.sink    cfg_i
);
  import uer_pkg::*;

  cfg_t      cfg;
  logic      tick_valid;
  logic      calc_ready;
  tick_res_t tick_res;
  logic      u_tick_valid_seen;

  // settings
  uer_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // per-tick state update: counters, trigger, report, echo timing
  uer_tick u_tick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .ready_i (calc_ready),
    .valid_o (tick_valid),
    .res_o   (tick_res)
  );

  // distance, obstacle, digits and blink period
  uer_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (tick_valid),
    .res_i   (tick_res),
    .ready_o (calc_ready),
    .out_o   (out_o)
  );

  assign u_tick_valid_seen = tick_valid;

  // input only backs up when the result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  // digits are always decimal ascii
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.hundreds_char >= 6'd48 && out_o.hundreds_char <= 6'd57 &&
                     out_o.tens_char >= 6'd48 && out_o.tens_char <= 6'd57 &&
                     out_o.units_char >= 6'd48 && out_o.units_char <= 6'd57))
    else $error("centimetre digit out of range");

  // the pipeline cannot drop a request: an accepted tick keeps the chain non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (u_tick_valid_seen))
    else $error("accepted tick lost");

endmodule

@@ tb/sv/tb.sv @@
// testbench of the echo ranger: tick stimulus, per-tick predictor and result checker
`timescale 1ns / 1ps
module tb;
  import uer_pkg::*;

  // cycles to let pass once the result queue is empty: the block keeps four stages
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles with no accepted request before the run is abandoned
  localparam int unsigned QUIET_LIMIT   = 2000;
  // long receiver hold-off used to fill the pipeline
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned PHASE_TICKS   = 100;
  localparam int unsigned PHASES        = 8;

  typedef enum int unsigned {
    SET_MIN,
    SET_MAX,
    SET_RANDOM
  } setting_mode_e;

  // one result of the block, at the port widths
  typedef struct packed {
    logic        trigger;
    logic        done;
    logic [15:0] ticks;
    logic [31:0] distance;
    logic        obstacle;
    logic [5:0]  hundreds;
    logic [5:0]  tens;
    logic [5:0]  units;
    logic [15:0] blink;
    logic        report;
  } ranger_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uer_in_if  tick_if ();
  uer_out_if res_if ();
  uer_cfg_if cfg_if ();

  ultrasonic_echo_ranger i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow settings, updated on every accepted register write
  logic [15:0] ping_period  = PING_PERIOD_RST;
  logic [7:0]  report_every = REPORT_EVERY_RST;
  logic [15:0] um_per_tick  = UM_PER_TICK_RST;
  logic [31:0] obst_thresh  = OBST_THRESH_RST;
  logic [7:0]  blink_mult   = BLINK_MULT_RST;

  // shadow ranging state
  logic [15:0] tick_cnt   = '0;
  logic [7:0]  period_cnt = '0;
  logic        echo_prev  = 1'b0;
  logic [15:0] echo_start = '0;
  logic [15:0] echo_len   = TICKS_RST;
  logic [31:0] dist_um    = DISTANCE_RST;
  logic        obst_flag  = 1'b1;

  ranger_result_t expected_results[$];

  // stimulus shaping shared by the sender and the receiver
  bit          idle_en = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  // run statistics
  int unsigned fail_count = 0;
  int unsigned ticks_taken = 0;
  int unsigned results_checked = 0;
  int unsigned trig_seen = 0;
  int unsigned meas_seen = 0;
  int unsigned report_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;

  // advance the shadow state by one tick and return what the block should give
  function automatic ranger_result_t range_one_tick(input logic echo);
    ranger_result_t r;
    int unsigned    cm;
    logic [23:0]    blink_prod;
    r = '0;
    // the counter moves on first, then a trigger clears it
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= ping_period) begin
      r.trigger  = 1'b1;
      tick_cnt   = '0;
      period_cnt = period_cnt + 8'd1;
    end
    if (period_cnt >= report_every) begin
      r.report   = 1'b1;
      period_cnt = '0;
    end
    // echo edges are taken against the updated counter
    if (echo != echo_prev) begin
      if (echo) begin
        echo_start = tick_cnt;
      end else begin
        echo_len  = tick_cnt - echo_start;
        dist_um   = 32'(echo_len) * 32'(um_per_tick);
        obst_flag = (dist_um <= obst_thresh);
        r.done    = 1'b1;
      end
    end
    echo_prev = echo;
    cm = dist_um / 10000;
    if (cm > 32'(CM_MAX)) cm = 32'(CM_MAX);
    blink_prod = 24'(echo_len) * 24'(blink_mult);
    r.ticks    = echo_len;
    r.distance = dist_um;
    r.obstacle = obst_flag;
    r.hundreds = ASCII_ZERO + 6'(cm / 100);
    r.tens     = ASCII_ZERO + 6'((cm / 10) % 10);
    r.units    = ASCII_ZERO + 6'(cm % 10);
    r.blink    = (blink_prod > 24'hFFFF) ? 16'hFFFF : blink_prod[15:0];
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // everything is sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    ranger_result_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        // values are masked to the register widths, unknown indexes change nothing
        case (cfg_if.index)
          CFG_PING_PERIOD:  ping_period  = cfg_if.data[15:0];
          CFG_REPORT_EVERY: report_every = cfg_if.data[7:0];
          CFG_UM_PER_TICK:  um_per_tick  = cfg_if.data[15:0];
          CFG_OBST_THRESH:  obst_thresh  = cfg_if.data;
          CFG_BLINK_MULT:   blink_mult   = cfg_if.data[7:0];
          default: ;
        endcase
      end
      if (tick_if.valid && tick_if.ready) begin
        expected_results.push_back(range_one_tick(tick_if.echo_level));
        ticks_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no tick outstanding, echo_ticks %0d", $time,
                   res_if.echo_ticks);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          trig_seen   += 32'(want.trigger);
          meas_seen   += 32'(want.done);
          report_seen += 32'(want.report);
          compare_field("trigger", 32'(want.trigger), 32'(res_if.trigger));
          compare_field("measurement_done", 32'(want.done),
                        32'(res_if.measurement_done));
          compare_field("echo_ticks", 32'(want.ticks), 32'(res_if.echo_ticks));
          compare_field("distance_um", want.distance, res_if.distance_um);
          compare_field("obstacle", 32'(want.obstacle), 32'(res_if.obstacle));
          compare_field("hundreds_char", 32'(want.hundreds), 32'(res_if.hundreds_char));
          compare_field("tens_char", 32'(want.tens), 32'(res_if.tens_char));
          compare_field("units_char", 32'(want.units), 32'(res_if.units_char));
          compare_field("blink_period", 32'(want.blink), 32'(res_if.blink_period));
          compare_field("report_pulse", 32'(want.report), 32'(res_if.report_pulse));
        end
      end
    end
  end

  // watchdog: any accepted request on any channel counts as progress
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(idle_en && ($urandom_range(99) < 9));
    end
  end

  // offer one tick from a falling edge and return at the falling edge after acceptance;
  // valid is left high so that back-to-back ticks leave no gap
  task automatic send_tick(input logic echo);
    while (idle_en && ($urandom_range(99) < 9)) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid      <= 1'b1;
    tick_if.echo_level <= echo;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender pauses until every expected result is in and the pipeline has emptied
  task automatic drain_results();
    tick_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // leaves valid high; the caller lowers it after its last write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write all five settings on an idle block; unused upper data bits carry noise
  task automatic apply_settings(input logic [15:0] ping, input logic [7:0] rep,
                                input logic [15:0] scale, input logic [31:0] thr,
                                input logic [7:0] mult);
    drain_results();
    cfg_write(CFG_PING_PERIOD, {16'($urandom), ping});
    cfg_write(CFG_REPORT_EVERY, {24'($urandom), rep});
    cfg_write(CFG_UM_PER_TICK, {16'($urandom), scale});
    cfg_write(CFG_OBST_THRESH, thr);
    cfg_write(CFG_BLINK_MULT, {24'($urandom), mult});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pick_settings(input setting_mode_e mode);
    logic [15:0] scale;
    case (mode)
      SET_MIN: begin
        apply_settings(16'd1, 8'd1, 16'd1, 32'd0, 8'd0);
      end
      SET_MAX: begin
        apply_settings(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
      end
      default: begin
        scale = 16'($urandom);
        // threshold near typical distances so the obstacle flag goes both ways
        apply_settings(16'($urandom_range(2, 40)), 8'($urandom_range(1, 6)), scale,
                       32'(scale) * 32'($urandom_range(0, 40)), 8'($urandom));
      end
    endcase
  endtask

  // mostly well-formed echo pulses of random length, with some single noisy ticks
  task automatic send_echo_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned lo;
    int unsigned hi;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(4) == 0) begin
        send_tick(1'($urandom));
        sent++;
      end else begin
        lo = $urandom_range(0, 12);
        // now and then a long echo, so that it spans a counter clear
        hi = ($urandom_range(7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 30);
        repeat (lo) send_tick(1'b0);
        repeat (hi) send_tick(1'b1);
        sent += lo + hi;
      end
    end
  endtask

  // reset defaults: no echo seen yet, so digits read 999 and obstacle is set
  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // an echo that starts before a counter clear and ends after it gives a wrapped
  // length; full scale then saturates both the centimetre digits and the blink period
  task automatic test_echo_wrap();
    apply_settings(16'd4, 8'd1, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    // the counter stands at 2 after the reset test
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // zero ping and report periods fire on every tick; zero-length echo gives 000
  task automatic test_zero_periods();
    apply_settings(16'd0, 8'd0, 16'd1, 32'd0, 8'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // period lowered below the running count fires on the next tick
  task automatic test_lowered_period();
    apply_settings(16'hFFFF, 8'hFF, 16'd8575, 32'd100000, 8'd80);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_results();
    cfg_write(CFG_PING_PERIOD, {16'hFFFF, 16'd2});
    cfg_if.valid <= 1'b0;
    send_tick(1'b0);
  endtask

  // writes to unknown indexes are dropped; a new multiplier shows in blink at once
  task automatic test_register_writes();
    drain_results();
    for (int i = int'(CFG_BLINK_MULT) + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), $urandom);
    end
    cfg_write(CFG_BLINK_MULT, {24'hABCDEF, 8'($urandom_range(1, 255))});
    cfg_if.valid <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls;
  // then the sender waits for every result before carrying on
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    send_echo_traffic(40);
    drain_results();
    send_echo_traffic(20);
  endtask

  task automatic test_random_traffic();
    setting_mode_e mode;
    for (int unsigned p = 0; p < PHASES; p++) begin
      mode = (p == 1) ? SET_MIN : (p == 4) ? SET_MAX : SET_RANDOM;
      pick_settings(mode);
      // one phase with no idling on either side
      idle_en = (p != 2);
      send_echo_traffic(PHASE_TICKS);
      if (p == 5) test_backpressure();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    tick_if.valid      = 1'b0;
    tick_if.echo_level = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_echo_wrap();
    test_zero_periods();
    test_lowered_period();
    test_register_writes();
    test_random_traffic();

    drain_results();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      fail_count++;
    end
    $display("covered %0d ticks and %0d register writes, %0d results checked",
             ticks_taken, reg_writes, results_checked);
    $display("  with %0d trigger pulses, %0d measurements, %0d report pulses, %0d errors",
             trig_seen, meas_seen, report_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/uer_pkg.sv
hdl/uer_if.sv
hdl/uer_regs.sv
hdl/uer_tick.sv
hdl/uer_calc.sv
hdl/ultrasonic_echo_ranger.sv
tb/sv/tb.sv
